FILE: hw/rtl/sdq_pkg.sv
// Shared types and constants for the signal dispatch queue.
// Has no dependencies; the files that use it refer to it by scoped names.
package sdq_pkg;

    localparam int NUM_SOURCES_DEF = 16;
    localparam int NUM_LEVELS_DEF  = 4;
    localparam int RING_DEPTH_DEF  = 8;
    localparam int ARG_WIDTH_DEF   = 32;

    localparam logic [2:0] CMD_CREATE  = 3'd0;
    localparam logic [2:0] CMD_DELETE  = 3'd1;
    localparam logic [2:0] CMD_SEND    = 3'd2;
    localparam logic [2:0] CMD_PROCESS = 3'd3;
    localparam logic [2:0] CMD_SETPRI  = 3'd4;
    localparam logic [2:0] CMD_QUERY   = 3'd5;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_INV_OBJ  = 3'd1;
    localparam logic [2:0] ST_INV_VAL  = 3'd2;
    localparam logic [2:0] ST_INV_PRIO = 3'd3;
    localparam logic [2:0] ST_OVERFLOW = 3'd4;
    localparam logic [2:0] ST_EMPTY    = 3'd5;

    // One entry of the source table.
    typedef struct packed {
        logic       created;
        logic       has_ring;
        logic [3:0] count;
        logic [3:0] limit;
        logic [2:0] level;
        logic [3:0] rd_idx;
        logic [3:0] wr_idx;
    } src_t;

endpackage

FILE: hw/rtl/sdq_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// Used for the argument store and the link tables; no package dependency.
module sdq_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

FILE: hw/rtl/sdq_src_table.sv
// Source table memory with one valid bit per entry; an entry never written
// since reset reads as all zero. Depends on sdq_pkg for the entry type.
module sdq_src_table #(
    parameter int NUM_SOURCES = sdq_pkg::NUM_SOURCES_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           we,
    input  logic [$clog2(NUM_SOURCES)-1:0] waddr,
    input  sdq_pkg::src_t                  wdata,
    input  logic                           re,
    input  logic [$clog2(NUM_SOURCES)-1:0] raddr,
    output sdq_pkg::src_t                  rdata
);

    sdq_pkg::src_t                  mem [NUM_SOURCES];
    sdq_pkg::src_t                  rdata_reg;
    logic [NUM_SOURCES-1:0]         vld_reg;
    logic                           rd_vld_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg    <= '0;
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            if (we)
            begin
                vld_reg[waddr] <= 1'b1;
            end
            if (re)
            begin
                rd_vld_reg <= vld_reg[raddr];
            end
        end
    end

    assign rdata = rd_vld_reg ? rdata_reg : '0;

endmodule

FILE: hw/rtl/signal_dispatch_queue_core.sv
// Signal dispatch queue: command sequencer, per-level list registers and the
// memories. Depends on sdq_pkg, sdq_src_table and sdq_ram.
//
//  channel   | handshake          | payload
//  ----------+--------------------+-----------------------------------------
//  command   | start / busy       | command, signal_id, priority_req,
//            |                    | depth_limit, use_ring, arg_value
//  result    | done (one cycle)   | status, served_valid, served_signal,
//            |                    | served_arg, pending_count, raised
//
// A command passes from transfer to done through one memory read, the evaluate
// state, the link-table write states S_REMOVE, S_APPEND and S_LINK for list
// removal and append (one link write port each), and the result state S_FINISH.
// Reset is asynchronous; the source table reads as empty right after it.
// A new command may be started in the cycle that done is high.
// The result side has no back-pressure, so nothing ever waits on the receiver.
module signal_dispatch_queue_core #(
    parameter int NUM_SOURCES = sdq_pkg::NUM_SOURCES_DEF,
    parameter int NUM_LEVELS  = sdq_pkg::NUM_LEVELS_DEF,
    parameter int RING_DEPTH  = sdq_pkg::RING_DEPTH_DEF,
    parameter int ARG_WIDTH   = sdq_pkg::ARG_WIDTH_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic [2:0]           command,
    input  logic [3:0]           signal_id,
    input  logic [2:0]           priority_req,
    input  logic [3:0]           depth_limit,
    input  logic                 use_ring,
    input  logic [ARG_WIDTH-1:0] arg_value,
    output logic                 done,
    output logic [2:0]           status,
    output logic                 served_valid,
    output logic [3:0]           served_signal,
    output logic [ARG_WIDTH-1:0] served_arg,
    output logic [3:0]           pending_count,
    output logic                 raised
);

    localparam int SRC_W = $clog2(NUM_SOURCES);
    localparam int LVL_W = (NUM_LEVELS > 1) ? $clog2(NUM_LEVELS) : 1;
    localparam int ARW   = $clog2(NUM_SOURCES * RING_DEPTH);

    typedef enum logic [2:0] {
        S_IDLE,
        S_EVAL,
        S_REMOVE,
        S_APPEND,
        S_LINK,
        S_FINISH
    } state_t;

    state_t state_reg;

    // Latched command.
    logic [2:0]           cmd_reg;
    logic [2:0]           lv_reg;
    logic                 lv_ok_reg;
    logic                 sid_ok_reg;
    logic [3:0]           lim_reg;
    logic                 ring_reg;
    logic [ARG_WIDTH-1:0] arg_reg;
    logic [SRC_W-1:0]     s_reg;

    // Evaluation results.
    logic [2:0]           status_reg;
    logic [3:0]           count_reg;
    logic                 valid_reg;
    logic                 arg_sel_reg;
    logic                 ap_reg;
    logic [LVL_W-1:0]     rm_lv_reg;
    logic [LVL_W-1:0]     ap_lv_reg;
    logic [SRC_W-1:0]     old_tail_reg;

    // Level lists.
    logic [SRC_W-1:0]     head_reg [NUM_LEVELS];
    logic [SRC_W-1:0]     tail_reg [NUM_LEVELS];
    logic [NUM_LEVELS-1:0] ne_reg;

    // Output registers.
    logic                 done_reg;
    logic [2:0]           status_o_reg;
    logic                 served_valid_reg;
    logic [3:0]           served_signal_reg;
    logic [ARG_WIDTH-1:0] served_arg_reg;
    logic [3:0]           pending_count_reg;
    logic                 raised_reg;

    // Memory ports.
    sdq_pkg::src_t        src_rdata;
    sdq_pkg::src_t        src_wdata;
    logic                 src_we;
    logic [SRC_W-1:0]     nxt_rdata;
    logic [SRC_W-1:0]     prv_rdata;
    logic                 nxt_we;
    logic [SRC_W-1:0]     nxt_waddr;
    logic [SRC_W-1:0]     nxt_wdata;
    logic                 prv_we;
    logic [SRC_W-1:0]     prv_waddr;
    logic [SRC_W-1:0]     prv_wdata;
    logic                 arg_we;
    logic                 arg_re;
    logic [ARW-1:0]       arg_addr;
    logic [ARG_WIDTH-1:0] arg_rdata;

    logic                 accept;
    logic                 in_lv_ok;
    logic [LVL_W-1:0]     in_lv_idx;
    logic [31:0]          sid_ext;
    logic [SRC_W-1:0]     s_in;
    logic [31:0]          lv_ext;

    // Evaluate-cycle decode.
    logic [2:0]           ev_status;
    logic [3:0]           ev_count;
    logic                 ev_valid;
    logic                 ev_src_we;
    sdq_pkg::src_t        ev_src;
    logic                 ev_rm;
    logic                 ev_ap;
    logic [LVL_W-1:0]     ev_rm_lv;
    logic [LVL_W-1:0]     ev_ap_lv;
    logic                 ev_arg_we;
    logic                 ev_arg_re;
    logic [3:0]           ev_arg_idx;
    logic                 ev_arg_sel;
    logic [LVL_W-1:0]     lv_idx_reg;
    logic                 ne_lv;
    logic [4:0]           idx_inc;

    logic                 rm_is_head;
    logic                 rm_is_tail;

    assign accept    = start && !busy;
    assign busy      = (state_reg != S_IDLE);
    assign lv_ext    = 32'(priority_req);
    assign in_lv_ok  = lv_ext < NUM_LEVELS;
    assign in_lv_idx = in_lv_ok ? lv_ext[LVL_W-1:0] : '0;
    assign sid_ext   = 32'(signal_id);
    assign s_in      = ((command == sdq_pkg::CMD_PROCESS) && in_lv_ok) ?
                       head_reg[in_lv_idx] : sid_ext[SRC_W-1:0];

    assign lv_idx_reg = lv_ok_reg ? lv_reg[LVL_W-1:0] : '0;
    assign ne_lv      = lv_ok_reg && ne_reg[lv_idx_reg];

    always_comb
    begin
        ev_status  = sdq_pkg::ST_OK;
        ev_count   = '0;
        ev_valid   = 1'b0;
        ev_src_we  = 1'b0;
        ev_src     = src_rdata;
        ev_rm      = 1'b0;
        ev_ap      = 1'b0;
        ev_rm_lv   = src_rdata.level[LVL_W-1:0];
        ev_ap_lv   = lv_idx_reg;
        ev_arg_we  = 1'b0;
        ev_arg_re  = 1'b0;
        ev_arg_idx = '0;
        ev_arg_sel = 1'b0;
        idx_inc    = '0;
        if (cmd_reg == sdq_pkg::CMD_PROCESS)
        begin
            if (!lv_ok_reg)
            begin
                ev_status = sdq_pkg::ST_INV_PRIO;
            end
            else if (!ne_lv)
            begin
                ev_status = sdq_pkg::ST_EMPTY;
            end
            else
            begin
                ev_count     = src_rdata.count - 4'd1;
                ev_src.count = ev_count;
                ev_src_we    = 1'b1;
                ev_rm        = 1'b1;
                ev_rm_lv     = lv_idx_reg;
                ev_ap        = (ev_count != 4'd0);
                ev_valid     = 1'b1;
                if (src_rdata.has_ring)
                begin
                    idx_inc       = {1'b0, src_rdata.rd_idx} + 5'd1;
                    ev_src.rd_idx = (idx_inc == {1'b0, src_rdata.limit}) ?
                                    4'd0 : idx_inc[3:0];
                    ev_arg_re     = 1'b1;
                    ev_arg_idx    = src_rdata.rd_idx;
                    ev_arg_sel    = 1'b1;
                end
                else if (src_rdata.limit == 4'd1)
                begin
                    ev_arg_re  = 1'b1;
                    ev_arg_sel = 1'b1;
                end
            end
        end
        else if (cmd_reg > sdq_pkg::CMD_QUERY)
        begin
            ev_status = sdq_pkg::ST_INV_VAL;
        end
        else if (!sid_ok_reg)
        begin
            ev_status = sdq_pkg::ST_INV_OBJ;
        end
        else if (cmd_reg == sdq_pkg::CMD_CREATE)
        begin
            if ((lim_reg == 4'd0) || (32'(lim_reg) > RING_DEPTH))
            begin
                ev_status = sdq_pkg::ST_INV_VAL;
            end
            else if (!lv_ok_reg)
            begin
                ev_status = sdq_pkg::ST_INV_PRIO;
            end
            else if (src_rdata.created)
            begin
                ev_status = sdq_pkg::ST_INV_OBJ;
            end
            else
            begin
                ev_src_we       = 1'b1;
                ev_src.created  = 1'b1;
                ev_src.has_ring = ring_reg;
                ev_src.count    = '0;
                ev_src.limit    = lim_reg;
                ev_src.level    = lv_reg;
                ev_src.rd_idx   = '0;
                ev_src.wr_idx   = '0;
            end
        end
        else if (((cmd_reg == sdq_pkg::CMD_SETPRI) || (cmd_reg == sdq_pkg::CMD_QUERY))
                 && !lv_ok_reg)
        begin
            ev_status = sdq_pkg::ST_INV_PRIO;
        end
        else if (!src_rdata.created)
        begin
            ev_status = sdq_pkg::ST_INV_OBJ;
        end
        else
        begin
            case (cmd_reg)
                sdq_pkg::CMD_DELETE:
                begin
                    ev_rm           = (src_rdata.count != 4'd0);
                    ev_src_we       = 1'b1;
                    ev_src.created  = 1'b0;
                    ev_src.has_ring = 1'b0;
                    ev_src.count    = '0;
                    ev_src.limit    = '0;
                    ev_src.rd_idx   = '0;
                    ev_src.wr_idx   = '0;
                end
                sdq_pkg::CMD_SEND:
                begin
                    if (src_rdata.count >= src_rdata.limit)
                    begin
                        ev_status = sdq_pkg::ST_OVERFLOW;
                        ev_count  = src_rdata.count;
                    end
                    else
                    begin
                        ev_count     = src_rdata.count + 4'd1;
                        ev_src.count = ev_count;
                        ev_src_we    = 1'b1;
                        ev_ap        = (src_rdata.count == 4'd0);
                        ev_ap_lv     = src_rdata.level[LVL_W-1:0];
                        if (src_rdata.has_ring)
                        begin
                            idx_inc       = {1'b0, src_rdata.wr_idx} + 5'd1;
                            ev_src.wr_idx = (idx_inc == {1'b0, src_rdata.limit}) ?
                                            4'd0 : idx_inc[3:0];
                            ev_arg_we     = 1'b1;
                            ev_arg_idx    = src_rdata.wr_idx;
                        end
                        else if (src_rdata.limit == 4'd1)
                        begin
                            ev_arg_we = 1'b1;
                        end
                    end
                end
                sdq_pkg::CMD_SETPRI:
                begin
                    ev_rm        = (src_rdata.count != 4'd0);
                    ev_ap        = (src_rdata.count != 4'd0);
                    ev_src_we    = 1'b1;
                    ev_src.level = lv_reg;
                    ev_count     = src_rdata.count;
                end
                default:
                begin
                    ev_count = src_rdata.count;
                end
            endcase
        end
    end

    assign rm_is_head = (head_reg[rm_lv_reg] == s_reg);
    assign rm_is_tail = (tail_reg[rm_lv_reg] == s_reg);

    // Memory write and read port control.
    always_comb
    begin
        src_we    = (state_reg == S_EVAL) && ev_src_we;
        src_wdata = ev_src;
        arg_we    = (state_reg == S_EVAL) && ev_arg_we;
        arg_re    = (state_reg == S_EVAL) && ev_arg_re;
        arg_addr  = ARW'(s_reg) * ARW'(RING_DEPTH) + ARW'(ev_arg_idx);
        nxt_we    = 1'b0;
        nxt_waddr = s_reg;
        nxt_wdata = s_reg;
        prv_we    = 1'b0;
        prv_waddr = s_reg;
        prv_wdata = s_reg;
        case (state_reg)
            S_REMOVE:
            begin
                // Unlinking from the middle patches both neighbors.
                if (!rm_is_head && !rm_is_tail)
                begin
                    nxt_we    = 1'b1;
                    nxt_waddr = prv_rdata;
                    nxt_wdata = nxt_rdata;
                    prv_we    = 1'b1;
                    prv_waddr = nxt_rdata;
                    prv_wdata = prv_rdata;
                end
            end
            S_APPEND:
            begin
                nxt_we    = 1'b1;
                prv_we    = 1'b1;
                prv_wdata = ne_reg[ap_lv_reg] ? tail_reg[ap_lv_reg] : s_reg;
            end
            S_LINK:
            begin
                nxt_we    = 1'b1;
                nxt_waddr = old_tail_reg;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= S_IDLE;
            ne_reg            <= '0;
            done_reg          <= 1'b0;
            status_o_reg      <= sdq_pkg::ST_OK;
            served_valid_reg  <= 1'b0;
            served_signal_reg <= '0;
            served_arg_reg    <= '0;
            pending_count_reg <= '0;
            raised_reg        <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        state_reg <= S_EVAL;
                    end
                end
                S_EVAL:
                begin
                    if (ev_rm)
                    begin
                        state_reg <= S_REMOVE;
                    end
                    else if (ev_ap)
                    begin
                        state_reg <= S_APPEND;
                    end
                    else
                    begin
                        state_reg <= S_FINISH;
                    end
                end
                S_REMOVE:
                begin
                    if (rm_is_head && rm_is_tail)
                    begin
                        ne_reg[rm_lv_reg] <= 1'b0;
                    end
                    state_reg <= ap_reg ? S_APPEND : S_FINISH;
                end
                S_APPEND:
                begin
                    ne_reg[ap_lv_reg] <= 1'b1;
                    state_reg <= ne_reg[ap_lv_reg] ? S_LINK : S_FINISH;
                end
                S_LINK:
                begin
                    state_reg <= S_FINISH;
                end
                S_FINISH:
                begin
                    done_reg          <= 1'b1;
                    status_o_reg      <= status_reg;
                    served_valid_reg  <= valid_reg;
                    served_signal_reg <= valid_reg ? 4'(s_reg) : '0;
                    served_arg_reg    <= arg_sel_reg ? arg_rdata : '0;
                    pending_count_reg <= count_reg;
                    raised_reg        <= ne_lv;
                    state_reg         <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // Command latches, evaluation results and list pointers.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg    <= command;
            lv_reg     <= priority_req;
            lv_ok_reg  <= in_lv_ok;
            sid_ok_reg <= sid_ext < NUM_SOURCES;
            lim_reg    <= depth_limit;
            ring_reg   <= use_ring;
            arg_reg    <= arg_value;
            s_reg      <= s_in;
        end
        if (state_reg == S_EVAL)
        begin
            status_reg  <= ev_status;
            count_reg   <= ev_count;
            valid_reg   <= ev_valid;
            arg_sel_reg <= ev_arg_sel;
            ap_reg      <= ev_ap;
            rm_lv_reg   <= ev_rm_lv;
            ap_lv_reg   <= ev_ap_lv;
        end
        if (state_reg == S_REMOVE)
        begin
            if (rm_is_head && !rm_is_tail)
            begin
                head_reg[rm_lv_reg] <= nxt_rdata;
            end
            else if (rm_is_tail && !rm_is_head)
            begin
                tail_reg[rm_lv_reg] <= prv_rdata;
            end
        end
        if (state_reg == S_APPEND)
        begin
            old_tail_reg <= tail_reg[ap_lv_reg];
            if (!ne_reg[ap_lv_reg])
            begin
                head_reg[ap_lv_reg] <= s_reg;
            end
            tail_reg[ap_lv_reg] <= s_reg;
        end
    end

    sdq_src_table #(
        .NUM_SOURCES(NUM_SOURCES)
    ) u_src_table (
        .clk   (clk),
        .rst_n (rst_n),
        .we    (src_we),
        .waddr (s_reg),
        .wdata (src_wdata),
        .re    (accept),
        .raddr (s_in),
        .rdata (src_rdata)
    );

    sdq_ram #(
        .DEPTH(NUM_SOURCES),
        .WIDTH(SRC_W)
    ) u_next_ram (
        .clk   (clk),
        .we    (nxt_we),
        .waddr (nxt_waddr),
        .wdata (nxt_wdata),
        .re    (accept),
        .raddr (s_in),
        .rdata (nxt_rdata)
    );

    sdq_ram #(
        .DEPTH(NUM_SOURCES),
        .WIDTH(SRC_W)
    ) u_prev_ram (
        .clk   (clk),
        .we    (prv_we),
        .waddr (prv_waddr),
        .wdata (prv_wdata),
        .re    (accept),
        .raddr (s_in),
        .rdata (prv_rdata)
    );

    sdq_ram #(
        .DEPTH(NUM_SOURCES * RING_DEPTH),
        .WIDTH(ARG_WIDTH)
    ) u_arg_ram (
        .clk   (clk),
        .we    (arg_we),
        .waddr (arg_addr),
        .wdata (arg_reg),
        .re    (arg_re),
        .raddr (arg_addr),
        .rdata (arg_rdata)
    );

    assign done          = done_reg;
    assign status        = status_o_reg;
    assign served_valid  = served_valid_reg;
    assign served_signal = served_signal_reg;
    assign served_arg    = served_arg_reg;
    assign pending_count = pending_count_reg;
    assign raised        = raised_reg;

`ifndef ASSERT_OFF
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobe while a command is in flight");

    a_served_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (done && served_valid) |-> (status == sdq_pkg::ST_OK))
        else $error("served source reported with a failing status");

    a_accept_eval: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == S_EVAL))
        else $error("accepted command did not enter evaluation");

    a_link_after_append: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_LINK) |-> ($past(state_reg) == S_APPEND))
        else $error("tail link written outside an append");
`endif

endmodule

FILE: sim/tb_signal_dispatch_queue_core.sv
// Self-checking testbench for signal_dispatch_queue_core.
// Depends on sdq_pkg and the core; a behavioral queue model predicts each result.
module tb_signal_dispatch_queue_core;

    localparam int NSRC = 16;
    localparam int NLVL = 4;
    localparam int RDEP = 8;
    localparam int CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic [2:0]  status;
        logic        served_valid;
        logic [3:0]  served_signal;
        logic [31:0] served_arg;
        logic [3:0]  pending_count;
        logic        raised;
    } outcome_t;

    class dispatch_scoreboard;
        bit          created [NSRC];
        bit          has_ring [NSRC];
        int unsigned cnt [NSRC];
        int unsigned lim [NSRC];
        int unsigned lvl [NSRC];
        int unsigned rd [NSRC];
        int unsigned wr [NSRC];
        logic [31:0] ring [NSRC*RDEP];
        logic [31:0] slot [NSRC];
        int unsigned nxt [NSRC];
        int unsigned prv [NSRC];
        int unsigned head [NLVL];
        int unsigned tail [NLVL];
        bit          busy_lvl [NLVL];
        outcome_t    pending_results [$];
        int          errors;

        function void link_tail(int unsigned lv, int unsigned s);
            if (busy_lvl[lv]) begin
                nxt[tail[lv]] = s;
                prv[s] = tail[lv];
            end else begin
                head[lv] = s;
                prv[s] = s;
                busy_lvl[lv] = 1;
            end
            nxt[s] = s;
            tail[lv] = s;
        endfunction

        function void unlink(int unsigned lv, int unsigned s);
            bit h;
            bit t;
            h = head[lv] == s;
            t = tail[lv] == s;
            if (h && t) busy_lvl[lv] = 0;
            else if (h) head[lv] = nxt[s];
            else if (t) tail[lv] = prv[s];
            else begin
                nxt[prv[s]] = nxt[s];
                prv[nxt[s]] = prv[s];
            end
        endfunction

        // Applies one accepted command to the model and queues its result.
        function void note_command(logic [2:0] cmd, logic [3:0] sid, logic [2:0] lv,
                                   logic [3:0] dl, logic ur, logic [31:0] arg);
            outcome_t o;
            bit lv_ok;
            int unsigned s;
            int unsigned r;
            o = '0;
            o.status = sdq_pkg::ST_OK;
            lv_ok = lv < NLVL;
            if (cmd == sdq_pkg::CMD_PROCESS) begin
                if (!lv_ok) o.status = sdq_pkg::ST_INV_PRIO;
                else if (!busy_lvl[lv]) o.status = sdq_pkg::ST_EMPTY;
                else begin
                    s = head[lv];
                    cnt[s]--;
                    unlink(lv, s);
                    if (cnt[s] != 0) link_tail(lv, s);
                    if (has_ring[s]) begin
                        r = rd[s] % lim[s];
                        o.served_arg = ring[s*RDEP + r];
                        rd[s] = (r + 1) % lim[s];
                    end else if (lim[s] == 1) o.served_arg = slot[s];
                    o.served_valid = 1;
                    o.served_signal = 4'(s);
                    o.pending_count = 4'(cnt[s]);
                end
            end else if (cmd > sdq_pkg::CMD_QUERY) o.status = sdq_pkg::ST_INV_VAL;
            else if (cmd == sdq_pkg::CMD_CREATE) begin
                if (dl == 0 || dl > RDEP) o.status = sdq_pkg::ST_INV_VAL;
                else if (!lv_ok) o.status = sdq_pkg::ST_INV_PRIO;
                else if (created[sid]) o.status = sdq_pkg::ST_INV_OBJ;
                else begin
                    created[sid] = 1;
                    has_ring[sid] = ur;
                    cnt[sid] = 0;
                    lim[sid] = dl;
                    lvl[sid] = lv;
                    rd[sid] = 0;
                    wr[sid] = 0;
                end
            end else if ((cmd == sdq_pkg::CMD_SETPRI || cmd == sdq_pkg::CMD_QUERY) && !lv_ok)
                o.status = sdq_pkg::ST_INV_PRIO;
            else if (!created[sid]) o.status = sdq_pkg::ST_INV_OBJ;
            else if (cmd == sdq_pkg::CMD_DELETE) begin
                if (cnt[sid] != 0) unlink(lvl[sid], sid);
                created[sid] = 0;
                has_ring[sid] = 0;
                cnt[sid] = 0;
                lim[sid] = 0;
                rd[sid] = 0;
                wr[sid] = 0;
            end else if (cmd == sdq_pkg::CMD_SEND) begin
                if (cnt[sid] >= lim[sid]) o.status = sdq_pkg::ST_OVERFLOW;
                else begin
                    cnt[sid]++;
                    if (has_ring[sid]) begin
                        r = wr[sid] % lim[sid];
                        ring[sid*RDEP + r] = arg;
                        wr[sid] = (r + 1) % lim[sid];
                    end else if (lim[sid] == 1) slot[sid] = arg;
                    if (cnt[sid] == 1) link_tail(lvl[sid], sid);
                end
                o.pending_count = 4'(cnt[sid]);
            end else if (cmd == sdq_pkg::CMD_SETPRI) begin
                if (cnt[sid] != 0) unlink(lvl[sid], sid);
                lvl[sid] = lv;
                if (cnt[sid] != 0) link_tail(lv, sid);
                o.pending_count = 4'(cnt[sid]);
            end else o.pending_count = 4'(cnt[sid]);
            o.raised = lv_ok && busy_lvl[lv];
            pending_results.push_back(o);
        endfunction

        function void check_result(outcome_t got);
            outcome_t exp_o;
            if (pending_results.size() == 0) begin
                $error("result with no command outstanding");
                errors++;
                return;
            end
            exp_o = pending_results.pop_front();
            if (got.status !== exp_o.status) begin
                $error("status expected %0d actual %0d", exp_o.status, got.status);
                errors++;
            end
            if (got.served_valid !== exp_o.served_valid) begin
                $error("served_valid expected %0d actual %0d",
                       exp_o.served_valid, got.served_valid);
                errors++;
            end
            if (got.served_signal !== exp_o.served_signal) begin
                $error("served_signal expected %0d actual %0d",
                       exp_o.served_signal, got.served_signal);
                errors++;
            end
            if (got.served_arg !== exp_o.served_arg) begin
                $error("served_arg expected %h actual %h", exp_o.served_arg, got.served_arg);
                errors++;
            end
            if (got.pending_count !== exp_o.pending_count) begin
                $error("pending_count expected %0d actual %0d",
                       exp_o.pending_count, got.pending_count);
                errors++;
            end
            if (got.raised !== exp_o.raised) begin
                $error("raised expected %0d actual %0d", exp_o.raised, got.raised);
                errors++;
            end
        endfunction
    endclass

    logic        clk = 0;
    logic        rst_n = 0;
    logic        start = 0;
    logic        busy;
    logic [2:0]  command = '0;
    logic [3:0]  signal_id = '0;
    logic [2:0]  priority_req = '0;
    logic [3:0]  depth_limit = '0;
    logic        use_ring = 0;
    logic [31:0] arg_value = '0;
    logic        done;
    logic [2:0]  status;
    logic        served_valid;
    logic [3:0]  served_signal;
    logic [31:0] served_arg;
    logic [3:0]  pending_count;
    logic        raised;
    int          cycle_count = 0;

    dispatch_scoreboard board = new();

    signal_dispatch_queue_core uut (.*);

    always #10 clk = ~clk;

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    always @(posedge clk)
        if (rst_n && done)
            board.check_result({status, served_valid, served_signal, served_arg,
                                pending_count, raised});

    // Drives one command and holds it until the transfer; start drops only
    // when a gap follows, so it is never lowered and raised in one step.
    task automatic issue(logic [2:0] cmd, logic [3:0] sid, logic [2:0] lv,
                         logic [3:0] dl, logic ur, logic [31:0] arg, int gap);
        if (gap > 0) begin
            start <= 0;
            repeat (gap) @(posedge clk);
        end
        start <= 1;
        command <= cmd;
        signal_id <= sid;
        priority_req <= lv;
        depth_limit <= dl;
        use_ring <= ur;
        arg_value <= arg;
        do @(posedge clk); while (busy);
        board.note_command(cmd, sid, lv, dl, ur, arg);
    endtask

    task automatic rand_issue(logic [2:0] cmd, logic [3:0] sid, logic [2:0] lv,
                              logic [3:0] dl, logic ur, logic [31:0] arg);
        int gap;
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 7);
        issue(cmd, sid, lv, dl, ur, arg, gap);
    endtask

    task automatic drain();
        start <= 0;
        @(posedge clk);
        while (board.pending_results.size() != 0) @(posedge clk);
    endtask

    initial begin
        int k;
        int pick;
        logic [2:0] cmd;
        logic [31:0] word;
        repeat (10) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // Directed: bad limits, bad level, double create, overflow, both arg modes.
        issue(sdq_pkg::CMD_CREATE, 0, 0, 0, 1, '0, 0);
        issue(sdq_pkg::CMD_CREATE, 0, 0, 9, 1, '0, 0);
        issue(sdq_pkg::CMD_CREATE, 0, 7, 8, 1, '0, 0);
        issue(sdq_pkg::CMD_CREATE, 0, 0, 8, 1, '0, 0);
        issue(sdq_pkg::CMD_CREATE, 0, 0, 8, 1, '0, 0);
        issue(sdq_pkg::CMD_CREATE, 15, 3, 1, 0, '0, 1);
        issue(sdq_pkg::CMD_CREATE, 5, 0, 15, 0, '0, 0);
        issue(sdq_pkg::CMD_CREATE, 6, 0, 2, 0, '0, 0);
        issue(sdq_pkg::CMD_SEND, 15, 0, 0, 0, 32'hFFFF_FFFF, 0);
        issue(sdq_pkg::CMD_SEND, 15, 0, 0, 0, 32'h1234_5678, 0);
        issue(sdq_pkg::CMD_SEND, 0, 0, 0, 0, 32'hA5A5_5A5A, 2);
        issue(sdq_pkg::CMD_SEND, 6, 0, 0, 0, 32'h0000_0001, 0);
        issue(sdq_pkg::CMD_SEND, 3, 0, 0, 0, 32'h0, 0);
        issue(sdq_pkg::CMD_QUERY, 0, 7, 0, 0, '0, 0);
        issue(sdq_pkg::CMD_QUERY, 0, 0, 0, 0, '0, 0);
        issue(sdq_pkg::CMD_SETPRI, 0, 4, 0, 0, '0, 0);
        issue(sdq_pkg::CMD_SETPRI, 0, 3, 0, 0, '0, 3);
        issue(sdq_pkg::CMD_PROCESS, 0, 5, 0, 0, '0, 0);
        issue(sdq_pkg::CMD_PROCESS, 0, 2, 0, 0, '0, 0);
        issue(sdq_pkg::CMD_PROCESS, 0, 3, 0, 0, '0, 0);
        issue(sdq_pkg::CMD_PROCESS, 0, 3, 0, 0, '0, 0);
        issue(sdq_pkg::CMD_PROCESS, 0, 0, 0, 0, '0, 0);
        issue(3'd6, 1, 0, 0, 0, '0, 0);
        issue(3'd7, 1, 0, 0, 0, '0, 0);
        issue(sdq_pkg::CMD_DELETE, 6, 0, 0, 0, '0, 0);
        issue(sdq_pkg::CMD_DELETE, 6, 0, 0, 0, '0, 0);

        // Random: mostly valid create/send/process traffic on few levels.
        for (k = 0; k < 530; k++) begin
            if (k == 260) drain();
            pick = $urandom_range(0, 99);
            word = $urandom();
            if (pick < 12) cmd = sdq_pkg::CMD_CREATE;
            else if (pick < 18) cmd = sdq_pkg::CMD_DELETE;
            else if (pick < 50) cmd = sdq_pkg::CMD_SEND;
            else if (pick < 80) cmd = sdq_pkg::CMD_PROCESS;
            else if (pick < 88) cmd = sdq_pkg::CMD_SETPRI;
            else if (pick < 96) cmd = sdq_pkg::CMD_QUERY;
            else cmd = 3'($urandom_range(6, 7));
            rand_issue(cmd, 4'($urandom_range(0, 15)),
                       3'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 7)
                                                      : $urandom_range(0, 3)),
                       4'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 15)
                                                      : $urandom_range(1, 8)),
                       1'($urandom_range(0, 1)), word);
        end
        drain();
        repeat (20) @(posedge clk);
        if (board.errors == 0 && board.pending_results.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end
endmodule

FILE: signal_dispatch_queue_core.f
hw/rtl/sdq_pkg.sv
hw/rtl/sdq_ram.sv
hw/rtl/sdq_src_table.sv
hw/rtl/signal_dispatch_queue_core.sv
sim/tb_signal_dispatch_queue_core.sv
